>>> rtl/core/crpd_pkg.sv
// ----------------------------------------------------------------------------
// crpd_pkg
// Shared types and constants of the response packet decoder: characters,
// record kinds and the record that travels from parser to output stage.
// ----------------------------------------------------------------------------
package crpd_pkg;

    // Characters of the control protocol
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_X     = 8'h58;

    // Field widths
    localparam int ID_W    = 4;
    localparam int VALUE_W = 30;
    localparam int METER_W = 20;  // holds six decimal digits

    // Field ids
    localparam logic [ID_W-1:0] ID_FREQ_MAIN = 4'd0;
    localparam logic [ID_W-1:0] ID_MODE_MAIN = 4'd2;
    localparam logic [ID_W-1:0] ID_TX        = 4'd4;
    localparam logic [ID_W-1:0] ID_METER_1   = 4'd5;
    localparam logic [ID_W-1:0] ID_LAST      = 4'd12;

    localparam logic [VALUE_W-1:0] METER_MAX = 30'd255;

    // Record queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    typedef enum logic [1:0] {
        K_FREQ,
        K_MODE,
        K_TX,
        K_METER
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         sel;    // side, vfo or meter index
        logic [VALUE_W-1:0] value;
    } t_rec;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

>>> rtl/core/crpd_front.sv
// ----------------------------------------------------------------------------
// crpd_front
// Byte parser: tracks the position in the packet, captures the command bytes,
// folds digit runs as they arrive and classifies the packet on ';'.
// ----------------------------------------------------------------------------
module crpd_front
    import crpd_pkg::*;
#(
    parameter int BUF_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_rec_push,
    output t_rec       o_rec
);

    localparam int CNT_W = $clog2(BUF_BYTES + 1);

    logic [CNT_W-1:0]   r_count, n_count;
    logic [7:0]         r_c0, r_c1, r_c2, r_c3;
    logic [VALUE_W-1:0] r_freq, n_freq;
    logic               r_frun, n_frun, r_fany, n_fany;
    logic [METER_W-1:0] r_meter, n_meter;
    logic               r_mrun, n_mrun, r_many, n_many;

    logic       is_term;
    logic       dig;
    logic [3:0] dval;
    logic       in_freq, in_meter;
    logic       ok_len2, ok_len4, ok_len8, ok_len10;
    logic       hit_fa, hit_md, hit_tx, hit_rm;

    assign is_term = (i_rx_byte == CH_SEMI);
    assign dig     = is_digit(i_rx_byte);
    assign dval    = i_rx_byte[3:0];

    // Number fields: frequency at bytes 2..10, meter at bytes 3..8
    assign in_freq  = (r_count >= CNT_W'(2)) && (r_count <= CNT_W'(10));
    assign in_meter = (r_count >= CNT_W'(3)) && (r_count <= CNT_W'(8));

    // Advance count and fold digits
    always_comb begin
        n_count = r_count;
        n_freq  = r_freq;
        n_frun  = r_frun;
        n_fany  = r_fany;
        n_meter = r_meter;
        n_mrun  = r_mrun;
        n_many  = r_many;
        if (i_accept) begin
            if (is_term) begin
                n_count = '0;
                n_freq  = '0;
                n_frun  = 1'b1;
                n_fany  = 1'b0;
                n_meter = '0;
                n_mrun  = 1'b1;
                n_many  = 1'b0;
            end else begin
                if (r_count < CNT_W'(BUF_BYTES)) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (in_freq && r_frun) begin
                    if (dig) begin
                        n_freq = (r_freq << 3) + (r_freq << 1) + VALUE_W'(dval);
                        n_fany = 1'b1;
                    end else begin
                        n_frun = 1'b0;
                    end
                end
                if (in_meter && r_mrun) begin
                    if (dig) begin
                        n_meter = (r_meter << 3) + (r_meter << 1) + METER_W'(dval);
                        n_many  = 1'b1;
                    end else begin
                        n_mrun = 1'b0;
                    end
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_frun  <= 1'b1;
            r_fany  <= 1'b0;
            r_mrun  <= 1'b1;
            r_many  <= 1'b0;
            r_freq  <= '0;
            r_meter <= '0;
        end else begin
            r_count <= n_count;
            r_frun  <= n_frun;
            r_fany  <= n_fany;
            r_mrun  <= n_mrun;
            r_many  <= n_many;
            r_freq  <= n_freq;
            r_meter <= n_meter;
        end
    end

    // Capture command bytes
    always_ff @(posedge i_clk) begin
        if (i_accept && !is_term) begin
            if (r_count == CNT_W'(0)) r_c0 <= i_rx_byte;
            if (r_count == CNT_W'(1)) r_c1 <= i_rx_byte;
            if (r_count == CNT_W'(2)) r_c2 <= i_rx_byte;
            if (r_count == CNT_W'(3)) r_c3 <= i_rx_byte;
        end
    end

    // Classify the packet on its terminator
    assign ok_len2  = (r_count >= CNT_W'(2));
    assign ok_len4  = (r_count >= CNT_W'(4));
    assign ok_len8  = (r_count >= CNT_W'(8));
    assign ok_len10 = (r_count >= CNT_W'(10));

    assign hit_fa = (r_c0 == CH_F) && ((r_c1 == CH_A) || (r_c1 == CH_B))
                    && ok_len10 && r_fany;
    assign hit_md = (r_c0 == CH_M) && (r_c1 == CH_D) && ok_len4 && is_digit(r_c3);
    assign hit_tx = (r_c0 == CH_T) && (r_c1 == CH_X);
    assign hit_rm = (r_c0 == CH_R) && (r_c1 == CH_M) && ok_len8 && r_many
                    && (r_c2 >= CH_ONE) && (r_c2 <= CH_EIGHT);

    always_comb begin
        o_rec = '{kind: K_TX, sel: 3'd0, value: '0};
        if (hit_fa) begin
            o_rec.kind  = K_FREQ;
            o_rec.sel   = {2'b00, r_c1 == CH_B};
            o_rec.value = r_freq;
        end else if (hit_md) begin
            o_rec.kind  = K_MODE;
            o_rec.sel   = {2'b00, r_c2 == CH_ONE};
            o_rec.value = VALUE_W'(r_c3[3:0]);
        end else if (hit_rm) begin
            o_rec.kind  = K_METER;
            o_rec.sel   = r_c2[2:0] - 3'd1;
            o_rec.value = VALUE_W'(r_meter);
        end else begin
            // ';' in the flag position reads as zero
            o_rec.value = VALUE_W'((r_count >= CNT_W'(3)) && (r_c2 == CH_ONE));
        end
    end

    assign o_rec_push = i_accept && is_term && ok_len2
                        && (hit_fa || hit_md || hit_tx || hit_rm);

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUF_BYTES))
        else $error("packet count beyond buffer size");

    a_term_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && is_term) |=> (r_count == '0) && r_frun && r_mrun)
        else $error("terminator did not restart the packet");

    a_short_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < CNT_W'(2)) |-> !o_rec_push)
        else $error("record from a short packet");
`endif

endmodule

>>> rtl/core/crpd_fifo.sv
// ----------------------------------------------------------------------------
// crpd_fifo
// Short record queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module crpd_fifo
    import crpd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_rec   i_rec,
    input  logic   i_pop,
    output t_rec   o_rec,
    output t_qstat o_stat
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QLVL_W-1:0] r_level, n_level;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_level == QLVL_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_level == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_rec        = r_mem[r_rptr];

    always_comb begin
        n_level = r_level;
        case ({do_push, do_pop})
            2'b10:   n_level = r_level + QLVL_W'(1);
            2'b01:   n_level = r_level - QLVL_W'(1);
            default: n_level = r_level;
        endcase
    end

    // Advance pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + QPTR_W'(1);
            if (do_pop)  r_rptr <= r_rptr + QPTR_W'(1);
            r_level <= n_level;
        end
    end

    // Store records
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

`ifndef SYNTHESIS
    a_level_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_ptr_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_level[QPTR_W-1:0])
        else $error("queue pointers disagree with level");
`endif

endmodule

>>> rtl/core/crpd_back.sv
// ----------------------------------------------------------------------------
// crpd_back
// Output stage: pulls records from the queue, forms id and value, clamps
// meter readings and holds the result until it is transferred.
// ----------------------------------------------------------------------------
module crpd_back
    import crpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rec               i_rec,
    input  t_qstat             i_qstat,
    output logic               o_qpop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [ID_W-1:0]    o_field_id,
    output logic [VALUE_W-1:0] o_field_value
);

    logic               r_valid;
    logic [ID_W-1:0]    r_id, n_id;
    logic [VALUE_W-1:0] r_value, n_value;

    // Refill when the output register is free or being transferred
    assign o_qpop = !i_qstat.empty && (!r_valid || i_pop);

    always_comb begin
        n_id    = ID_TX;
        n_value = i_rec.value;
        unique case (i_rec.kind)
            K_FREQ:  n_id = ID_FREQ_MAIN + ID_W'(i_rec.sel[0]);
            K_MODE:  n_id = ID_MODE_MAIN + ID_W'(i_rec.sel[0]);
            K_TX:    n_id = ID_TX;
            K_METER: begin
                n_id    = ID_METER_1 + ID_W'(i_rec.sel);
                n_value = (i_rec.value > METER_MAX) ? METER_MAX : i_rec.value;
            end
            default: n_id = ID_TX;
        endcase
    end

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_qpop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Load result
    always_ff @(posedge i_clk) begin
        if (o_qpop) begin
            r_id    <= n_id;
            r_value <= n_value;
        end
    end

    assign o_empty       = !r_valid;
    assign o_field_id    = r_id;
    assign o_field_value = r_value;

`ifndef SYNTHESIS
    a_id_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_id <= ID_LAST))
        else $error("field id out of range");

    a_meter_clamp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_id >= ID_METER_1)) |-> (r_value <= METER_MAX))
        else $error("meter value not clamped");

    a_refill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_valid && !i_qstat.empty) |=> r_valid)
        else $error("output stage idle while records wait");
`endif

endmodule

>>> rtl/core/cat_response_packet_decoder.sv
// A result passes the record queue and output register to the output ports
// after the ';' transfer that ends its packet; bytes before the ';' give no result.
// Throughput: one byte per cycle unless the queue is full; digits fold into accumulators as they arrive.
// A four-record queue between parser and output register absorbs pop stalls.
// Reset (synchronous, active low) clears the packet count, queue and output.
// ----------------------------------------------------------------------------
// cat_response_packet_decoder
// Decodes ';'-terminated ASCII responses of a transceiver control link into
// field update records (frequency, mode, transmit flag, meters).
// ----------------------------------------------------------------------------
module cat_response_packet_decoder
    import crpd_pkg::*;
#(
    parameter int BUF_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [ID_W-1:0]    o_field_id,
    output logic [VALUE_W-1:0] o_field_value
);

    logic   accept;
    logic   rec_push;
    t_rec   rec_in, rec_out;
    logic   qpop;
    t_qstat qstat;

    assign full   = qstat.full;
    assign accept = push && !full;

    // Parse and classify bytes
    crpd_front #(
        .BUF_BYTES (BUF_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .o_rec_push (rec_push),
        .o_rec      (rec_in)
    );

    // Queue records
    crpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .i_pop   (qpop),
        .o_rec   (rec_out),
        .o_stat  (qstat)
    );

    // Form and hold results
    crpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (rec_out),
        .i_qstat       (qstat),
        .o_qpop        (qpop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_field_id    (o_field_id),
        .o_field_value (o_field_value)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ';'-terminated response packet decoder. A driver
// pushes received bytes from a pending queue and pops update records, and a
// monitor checks them against a byte-level predictor of packet decoding.
// ----------------------------------------------------------------------------
module tb_top;
    import crpd_pkg::*;

    localparam int BUF_BYTES  = 16;
    localparam int DRAIN_MARK = 256;  // pending-queue entry: hold until drained
    localparam int MAX_GAP    = 11;

    localparam logic [ID_W-1:0] ID_FREQ_SUB = ID_FREQ_MAIN + 4'd1;
    localparam logic [ID_W-1:0] ID_MODE_SUB = ID_MODE_MAIN + 4'd1;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] value;
    } t_update;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_rx_byte;
    logic               empty;
    logic               pop;
    logic [ID_W-1:0]    o_field_id;
    logic [VALUE_W-1:0] o_field_value;

    cat_response_packet_decoder #(
        .BUF_BYTES(BUF_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_field_id    (o_field_id),
        .o_field_value (o_field_value)
    );

    // Predictor state: bytes of the packet being gathered
    logic [7:0] pkt_buf [BUF_BYTES];
    int         pkt_cnt = 0;

    int      byte_q [$];      // bytes still to send, with drain markers
    t_update update_q [$];    // decoded updates still to come out

    int   mismatches   = 0;
    bit   drv_busy     = 0;
    bit   byte_sent    = 0;
    bit   result_taken = 0;
    bit   send_calm    = 0;
    bit   pop_calm     = 0;
    int   send_gap     = 0;
    int   pop_gap      = 0;
    logic [7:0] cur_byte = 8'h00;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Byte i of the packet; the terminator sits just past the stored bytes
    function automatic logic [7:0] pkt_char(input int i);
        if (i < pkt_cnt)
            return pkt_buf[i];
        if (i == pkt_cnt)
            return CH_SEMI;
        return 8'h00;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Leading digit run of at most maxlen characters, inside the packet
    function automatic bit scan_number(input int pos, input int maxlen, input int len,
                                       output int unsigned val);
        int unsigned acc;
        bit          any;
        logic [7:0]  c;
        acc = 0;
        any = 0;
        for (int k = 0; k < maxlen && pos + k < len; k++) begin
            c = pkt_char(pos + k);
            if (!is_num(c))
                break;
            acc = acc * 10 + (c - CH_ZERO);
            any = 1;
        end
        val = acc;
        return any;
    endfunction

    // Decode the finished packet into at most one update
    function automatic bit decode_packet(output t_update upd);
        int          len;
        logic [7:0]  c0, c1, c2, c3;
        int unsigned v;
        len = pkt_cnt + 1;
        upd.id    = '0;
        upd.value = '0;
        if (len < 3)
            return 0;
        c0 = pkt_char(0);
        c1 = pkt_char(1);
        c2 = pkt_char(2);
        if (c0 == CH_F && (c1 == CH_A || c1 == CH_B)) begin
            if (len < 11 || !scan_number(2, 9, len, v))
                return 0;
            upd.id    = (c1 == CH_A) ? ID_FREQ_MAIN : ID_FREQ_SUB;
            upd.value = v[VALUE_W-1:0];
            return 1;
        end
        if (c0 == CH_M && c1 == CH_D) begin
            if (len < 4)
                return 0;
            c3 = pkt_char(3);
            if (!is_num(c3))
                return 0;
            upd.id    = (c2 == CH_ONE) ? ID_MODE_SUB : ID_MODE_MAIN;
            upd.value = VALUE_W'(c3 - CH_ZERO);
            return 1;
        end
        if (c0 == CH_T && c1 == CH_X) begin
            upd.id    = ID_TX;
            upd.value = (c2 == CH_ONE) ? 30'd1 : 30'd0;
            return 1;
        end
        if (c0 == CH_R && c1 == CH_M) begin
            if (len < 9 || c2 < CH_ONE || c2 > CH_EIGHT)
                return 0;
            if (!scan_number(3, 6, len, v))
                return 0;
            if (v > METER_MAX)
                v = METER_MAX;
            upd.id    = ID_METER_1 + ID_W'(c2 - CH_ONE);
            upd.value = v[VALUE_W-1:0];
            return 1;
        end
        return 0;
    endfunction

    // Advance the predictor by one accepted byte
    task automatic track_byte(input logic [7:0] b);
        t_update upd;
        if (b == CH_SEMI) begin
            if (decode_packet(upd))
                update_q.push_back(upd);
            pkt_cnt = 0;
        end else if (pkt_cnt < BUF_BYTES) begin
            pkt_buf[pkt_cnt] = b;
            pkt_cnt++;
        end
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_any();
        return 8'($urandom_range(0, 255));
    endfunction

    // Append one random packet, mostly well formed, some broken or noise
    task automatic add_random_packet();
        int kind;
        int n;
        int r;
        logic [7:0] lead [4];
        lead = '{CH_F, CH_M, CH_T, CH_R};
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            // frequency, mostly nine digits
            byte_q.push_back(CH_F);
            byte_q.push_back($urandom_range(0, 1) ? CH_A : CH_B);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 9;
            for (int i = 0; i < n; i++)
                byte_q.push_back(($urandom_range(0, 15) == 0) ? rand_any() : rand_digit());
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (int i = 0; i < n; i++)
                byte_q.push_back(rand_digit());
            byte_q.push_back(CH_SEMI);
        end else if (kind < 35) begin
            // mode: side and mode digit
            put_text("MD");
            r = $urandom_range(0, 3);
            if (r == 0)
                byte_q.push_back(CH_ZERO);
            else if (r == 1)
                byte_q.push_back(CH_ONE);
            else if (r == 2)
                byte_q.push_back(rand_any());
            else if ($urandom_range(0, 1))
                byte_q.push_back(rand_digit());
            r = $urandom_range(0, 7);
            if (r == 0)
                byte_q.push_back(rand_any());
            else if (r != 1)
                byte_q.push_back(rand_digit());
            if ($urandom_range(0, 5) == 0)
                byte_q.push_back(rand_any());
            byte_q.push_back(CH_SEMI);
        end else if (kind < 50) begin
            // transmit flag
            put_text("TX");
            r = $urandom_range(0, 3);
            if (r == 0)
                byte_q.push_back(CH_ZERO);
            else if (r == 1)
                byte_q.push_back(CH_ONE);
            else if (r == 2)
                byte_q.push_back(rand_any());
            byte_q.push_back(CH_SEMI);
        end else if (kind < 75) begin
            // meter reading, often small enough to pass unclamped
            put_text("RM");
            byte_q.push_back(($urandom_range(0, 7) == 0) ? rand_any()
                                                         : CH_ONE + 8'($urandom_range(0, 7)));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 6;
            r = $urandom_range(0, 1);
            for (int i = 0; i < n; i++) begin
                if (r && i < 3)
                    byte_q.push_back(CH_ZERO);
                else
                    byte_q.push_back(($urandom_range(0, 15) == 0) ? rand_any() : rand_digit());
            end
            byte_q.push_back(CH_SEMI);
        end else if (kind < 85) begin
            // overlong packet behind a real command
            r = $urandom_range(0, 4);
            if (r == 0)
                put_text("FA");
            else if (r == 1)
                put_text("FB");
            else if (r == 2)
                put_text("MD0");
            else if (r == 3)
                put_text("TX1");
            else
                put_text("RM5");
            n = $urandom_range(12, 28);
            for (int i = 0; i < n; i++)
                byte_q.push_back(($urandom_range(0, 3) == 0) ? rand_any() : rand_digit());
            byte_q.push_back(CH_SEMI);
        end else if (kind < 92) begin
            // near miss on the command letters
            byte_q.push_back(lead[$urandom_range(0, 3)]);
            byte_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                byte_q.push_back(rand_digit());
            byte_q.push_back(CH_SEMI);
        end else begin
            // line noise
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                byte_q.push_back(rand_any());
            if ($urandom_range(0, 1))
                byte_q.push_back(CH_SEMI);
        end
    endtask

    // Driver and pop control: change inputs at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push      <= 1'b0;
            i_rx_byte <= 8'h00;
            pop       <= 1'b0;
        end else begin
            if (byte_sent) begin
                drv_busy  = 0;
                byte_sent = 0;
            end
            if (!drv_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (byte_q.size() > 0) begin
                    if (byte_q[0] == DRAIN_MARK) begin
                        if (update_q.size() == 0)
                            void'(byte_q.pop_front());
                    end else begin
                        cur_byte = 8'(byte_q.pop_front());
                        drv_busy = 1;
                        if ($urandom_range(0, 39) == 0)
                            send_calm = !send_calm;
                        send_gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
                    end
                end
            end
            push      <= drv_busy;
            i_rx_byte <= drv_busy ? cur_byte : rand_any();

            if (result_taken) begin
                result_taken = 0;
                if ($urandom_range(0, 19) == 0)
                    pop_calm = !pop_calm;
                pop_gap = pop_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Monitor: sample transfers at the rising edge, predict and check
    always @(posedge i_clk) begin
        t_update want;
        if (i_rst_n) begin
            if (push && !full) begin
                track_byte(i_rx_byte);
                byte_sent = 1;
            end
            if (pop && !empty) begin
                result_taken = 1;
                if (update_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected update: id %0d value %0d",
                                 o_field_id, o_field_value);
                end else begin
                    want = update_q.pop_front();
                    if (o_field_id !== want.id || o_field_value !== want.value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected id %0d value %0d, got id %0d value %0d",
                                     want.id, want.value, o_field_id, o_field_value);
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        i_rst_n = 1'b0;

        // Directed: byte extremes, and the TX, MD and FA commands with edge cases
        byte_q.push_back(8'hFF);
        put_text(";");
        put_text("TX;");
        put_text("TX1;");
        put_text("MD1;");
        put_text("MD19;");
        put_text("FA999999999;");
        byte_q.push_back(8'h00);
        put_text("B;");
        byte_q.push_back(DRAIN_MARK);

        // Random packets, with drain pauses midway
        while (byte_q.size() < 1030) begin
            if (byte_q.size() > 500 && byte_q.size() < 540)
                byte_q.push_back(DRAIN_MARK);
            add_random_packet();
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (byte_q.size() != 0 || drv_busy)
            @(posedge i_clk);
        while (update_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && update_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> cat_response_packet_decoder.f
rtl/core/crpd_pkg.sv
rtl/core/crpd_front.sv
rtl/core/crpd_fifo.sv
rtl/core/crpd_back.sv
rtl/core/cat_response_packet_decoder.sv
verif/tb_top.sv
